// File: src/bht_pkg.sv
`timescale 1ns / 1ps

package bht_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  localparam int DEF_NUM_BUCKETS = 64;
  localparam int DEF_SLOTS       = 4;

  localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_EXISTS    = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

endpackage

// File: src/bht_req_if.sv
`timescale 1ns / 1ps

interface bht_req_if;
  logic                       valid;
  logic                       ready;
  logic [bht_pkg::OP_W-1:0]   opcode;
  logic [bht_pkg::KEY_W-1:0]  key;
  logic [bht_pkg::VAL_W-1:0]  value;

  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink (input valid, input opcode, input key, input value, output ready);
endinterface

// File: src/bht_rsp_if.sv
`timescale 1ns / 1ps

interface bht_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bht_pkg::ST_W-1:0]   status;
  logic [bht_pkg::VAL_W-1:0]  found_value;

  modport source (output valid, output status, output found_value, input ready);
  modport sink (input valid, input status, input found_value, output ready);
endinterface

// File: src/bht_ram.sv
`timescale 1ns / 1ps

module bht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/bht_mod.sv
`timescale 1ns / 1ps

module bht_mod #(
  parameter int DIVISOR = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bht_pkg::KEY_W-1:0]    dividend,
  output logic                         done,
  output logic [$clog2(DIVISOR)-1:0]   rem
);
  import bht_pkg::*;

  localparam int               REM_W  = $clog2(DIVISOR);
  localparam int               PROD_W = 2 * KEY_W;
  localparam logic [KEY_W-1:0] RECIP  = KEY_W'((64'd1 << KEY_W) / 64'(DIVISOR));
  localparam logic [KEY_W-1:0] DIV_K  = KEY_W'(DIVISOR);

  logic [KEY_W-1:0]  x;
  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0]  quot;
  logic [KEY_W-1:0]  back;
  logic [KEY_W-1:0]  diff;
  logic [REM_W-1:0]  r;
  logic              prod_vld;
  logic              diff_vld;

  // truncated reciprocal gives a quotient low by at most one
  assign quot = prod[PROD_W-1 -: KEY_W];
  assign back = quot * DIV_K;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      diff_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      prod_vld <= start;
      diff_vld <= prod_vld;
      done     <= diff_vld;
    end
    if (start) begin
      x    <= dividend;
      prod <= PROD_W'(dividend) * PROD_W'(RECIP);
    end
    if (prod_vld) begin
      diff <= x - back;
    end
    if (diff_vld) begin
      if (diff >= DIV_K) begin
        r <= REM_W'(diff - DIV_K);
      end else begin
        r <= REM_W'(diff);
      end
    end
  end

  assign rem = r;

endmodule

// File: src/bucketed_hash_table.sv
`timescale 1ns / 1ps

// Key/value table of NUM_BUCKETS buckets with SLOTS entries each; a key lives in
// bucket key mod NUM_BUCKETS. Opcodes: find, insert (rejects a present key, then a
// full bucket), delete (needs key and value to match). Each word on req gives one
// word on rsp. All entries sit in one RAM of NUM_BUCKETS*SLOTS words with a
// registered read. After reset a clearing pass writes every entry invalid before
// the first request is taken. An operation goes from accept to result through the
// bucket remainder (reciprocal multiply, multiply back, one correction step), the
// bucket's entries streamed out of the RAM read port, the write-back and the load
// of the output register; req is ready again the cycle after the result is
// loaded, while the result may still wait on rsp.
module bucketed_hash_table #(
  parameter int NUM_BUCKETS = bht_pkg::DEF_NUM_BUCKETS,
  parameter int SLOTS       = bht_pkg::DEF_SLOTS
) (
  input  logic       clk,
  input  logic       rst,
  bht_req_if.sink    req,
  bht_rsp_if.source  rsp
);
  import bht_pkg::*;

  localparam int DEPTH  = NUM_BUCKETS * SLOTS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int BKT_W  = $clog2(NUM_BUCKETS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int ENT_W  = 1 + KEY_W + VAL_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr_idx;
  logic [OP_W-1:0]   op;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;
  logic [ADDR_W-1:0] base;
  logic [CNT_W-1:0]  iss;
  logic [CNT_W-1:0]  chk;
  logic              pend;
  logic              hit;
  logic [VAL_W-1:0]  hit_val;
  logic              free;
  logic [CNT_W-1:0]  free_idx;
  logic              del;
  logic [CNT_W-1:0]  del_idx;
  logic [ST_W-1:0]   res_status;
  logic [VAL_W-1:0]  res_value;
  logic              rsp_valid;
  logic [ST_W-1:0]   rsp_status;
  logic [VAL_W-1:0]  rsp_value;

  logic              accept;
  logic              mod_done;
  logic [BKT_W-1:0]  mod_rem;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ENT_W-1:0]  wdata;
  logic [ADDR_W-1:0] raddr;
  logic [ENT_W-1:0]  rdata;
  logic              r_valid;
  logic [KEY_W-1:0]  r_key;
  logic [VAL_W-1:0]  r_val;
  logic              key_eq;
  logic              do_insert;
  logic              do_delete;

  assign req.ready       = (state == S_IDLE);
  assign accept          = req.valid && req.ready;
  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.found_value = rsp_value;

  bht_mod #(
    .DIVISOR (NUM_BUCKETS)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (req.key),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  bht_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign r_valid = rdata[ENT_W-1];
  assign r_key   = rdata[VAL_W +: KEY_W];
  assign r_val   = rdata[VAL_W-1:0];
  assign key_eq  = r_valid && (r_key == key);
  assign raddr   = base + ADDR_W'(iss);

  assign do_insert = (op == OP_INSERT) && !hit && free;
  assign do_delete = (op == OP_DELETE) && del;

  always_comb begin
    we    = 1'b0;
    waddr = clr_idx;
    wdata = '0;
    if (state == S_CLEAR) begin
      we = 1'b1;
    end else if (state == S_WRITE) begin
      we = do_insert || do_delete;
      if (op == OP_INSERT) begin
        waddr = base + ADDR_W'(free_idx);
        wdata = {1'b1, key, value};
      end else begin
        waddr = base + ADDR_W'(del_idx);
      end
    end
  end

  always_comb begin
    res_value  = '0;
    res_status = ST_NOT_FOUND;
    case (op)
      OP_FIND: begin
        if (hit) begin
          res_status = ST_OK;
          res_value  = hit_val;
        end
      end
      OP_INSERT: begin
        if (hit) begin
          res_status = ST_EXISTS;
        end else if (free) begin
          res_status = ST_OK;
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (del) begin
          res_status = ST_OK;
        end
      end
      default: begin
        res_status = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      pend      <= 1'b0;
      iss       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op    <= req.opcode;
            key   <= req.key;
            value <= req.value;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            base  <= ADDR_W'(ADDR_W'(mod_rem) * ADDR_W'(SLOTS));
            iss   <= '0;
            pend  <= 1'b0;
            hit   <= 1'b0;
            free  <= 1'b0;
            del   <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (iss != CNT_W'(SLOTS)) begin
            iss  <= iss + 1'b1;
            pend <= 1'b1;
            chk  <= iss;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            if (key_eq && !hit) begin
              hit     <= 1'b1;
              hit_val <= r_val;
            end
            if (!r_valid && !free) begin
              free     <= 1'b1;
              free_idx <= chk;
            end
            if (key_eq && (r_val == value) && !del) begin
              del     <= 1'b1;
              del_idx <= chk;
            end
            if (chk == CNT_W'(SLOTS - 1)) begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= res_status;
            rsp_value  <= res_value;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/hash_table_checker.sv
`timescale 1ns / 1ps

module hash_table_checker #(
  parameter int NUM_BUCKETS = bht_pkg::DEF_NUM_BUCKETS,
  parameter int SLOTS       = bht_pkg::DEF_SLOTS
) (
  input  logic clk,
  input  logic rst,
  bht_req_if   req,
  bht_rsp_if   rsp,
  output int   errors,
  output int   outstanding,
  output int   checked,
  output int   status_count [4]
);
  import bht_pkg::*;

  localparam int DEPTH = NUM_BUCKETS * SLOTS;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] value;
  } lookup_t;

  logic             entry_used [DEPTH];
  logic [KEY_W-1:0] entry_key  [DEPTH];
  logic [VAL_W-1:0] entry_val  [DEPTH];
  lookup_t          answers_q [$];
  lookup_t          want;
  int               err_cnt = 0;
  int               chk_cnt = 0;
  int               st_cnt [4] = '{0, 0, 0, 0};

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] exp_val,
                                 input logic [VAL_W-1:0] got_val);
    $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, exp_val, got_val);
    err_cnt++;
  endtask

  function automatic lookup_t apply_request(input logic [OP_W-1:0] op,
                                            input logic [KEY_W-1:0] k,
                                            input logic [VAL_W-1:0] v);
    int      base;
    int      hit;
    int      free_slot;
    lookup_t r;
    base      = int'(k % KEY_W'(NUM_BUCKETS)) * SLOTS;
    hit       = -1;
    free_slot = -1;
    r.status  = ST_NOT_FOUND;
    r.value   = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (entry_used[base + s] && entry_key[base + s] == k && hit < 0) hit = base + s;
      if (!entry_used[base + s] && free_slot < 0) free_slot = base + s;
    end
    case (op)
      OP_FIND: begin
        if (hit >= 0) begin
          r.status = ST_OK;
          r.value  = entry_val[hit];
        end
      end
      OP_INSERT: begin
        if (hit >= 0) begin
          r.status = ST_EXISTS;
        end else if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          entry_used[free_slot] = 1'b1;
          entry_key[free_slot]  = k;
          entry_val[free_slot]  = v;
          r.status              = ST_OK;
        end
      end
      OP_DELETE: begin
        // keys are unique within a bucket, so the key hit is the only candidate
        if (hit >= 0 && entry_val[hit] == v) begin
          entry_used[hit] = 1'b0;
          r.status        = ST_OK;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (entry_used[i]) entry_used[i] = 1'b0;
      answers_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (answers_q.size() == 0) begin
          report_mismatch("word with nothing pending", '0, rsp.found_value);
        end else begin
          want = answers_q.pop_front();
          chk_cnt++;
          st_cnt[want.status]++;
          if (rsp.status !== want.status)
            report_mismatch("status", VAL_W'(want.status), VAL_W'(rsp.status));
          if (rsp.found_value !== want.value)
            report_mismatch("found_value", want.value, rsp.found_value);
        end
      end
      if (req.valid && req.ready)
        answers_q.push_back(apply_request(req.opcode, req.key, req.value));
    end
    errors       <= err_cnt;
    outstanding  <= answers_q.size();
    checked      <= chk_cnt;
    status_count <= st_cnt;
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bht_pkg::*;

  localparam int NUM_BUCKETS  = DEF_NUM_BUCKETS;
  localparam int SLOTS        = DEF_SLOTS;
  localparam int RANDOM_WORDS = 1950;
  localparam int HOLD_CYCLES  = 200;
  localparam int IDLE_LIMIT   = 3000;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bht_req_if req ();
  bht_rsp_if rsp ();

  int   errors;
  int   outstanding;
  int   checked;
  int   status_count [4];
  int   idle_cycles = 0;
  int   sent = 0;
  logic quiet = 1'b0;
  logic hold_request = 1'b0;

  logic [KEY_W-1:0] hot_tag [8];
  int               hot_bucket [8];
  logic [KEY_W-1:0] recent_key [$];
  logic [VAL_W-1:0] recent_val [$];

  bucketed_hash_table #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .SLOTS      (SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  hash_table_checker #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .SLOTS      (SLOTS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .errors      (errors),
    .outstanding (outstanding),
    .checked     (checked),
    .status_count(status_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                           input logic [VAL_W-1:0] v);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.opcode <= op;
    req.key    <= k;
    req.value  <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // response side
  initial begin
    int   stall;
    logic held;
    held = 1'b0;
    forever begin
      if (hold_request && !held) begin
        held = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet) begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          rsp.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    int               r;
    int               pick;

    req.valid  <= 1'b0;
    req.opcode <= OP_FIND;
    req.key    <= '0;
    req.value  <= '0;
    foreach (hot_tag[i]) begin
      hot_tag[i]    = $urandom();
      hot_bucket[i] = $urandom_range(0, NUM_BUCKETS - 1);
    end
    hot_tag[0] = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, extreme keys and values, duplicates, a full bucket
    send_word(OP_FIND, '0, '0);
    send_word(OP_INSERT, '0, '0);
    send_word(OP_INSERT, '1, '1);
    send_word(OP_FIND, '0, '1);
    send_word(OP_FIND, '1, '0);
    send_word(OP_INSERT, '1, 32'h0000_1234);
    for (int s = 0; s <= SLOTS; s++)
      send_word(OP_INSERT, KEY_W'(5 + s * NUM_BUCKETS), VAL_W'(32'hA000_0000 + s));
    send_word(OP_INSERT, KEY_W'(5), '0);
    send_word(OP_DELETE, KEY_W'(5), 32'hA000_0001);
    send_word(OP_DELETE, KEY_W'(5), 32'hA000_0000);
    send_word(OP_FIND, KEY_W'(5), '0);
    send_word(OP_DELETE, KEY_W'(5), 32'hA000_0000);
    send_word(OP_UNUSED, KEY_W'(5 + NUM_BUCKETS), '1);
    send_word(OP_INSERT, KEY_W'(5 + (SLOTS + 1) * NUM_BUCKETS), 32'h5555_5555);
    send_word(OP_FIND, KEY_W'(5 + (SLOTS + 1) * NUM_BUCKETS), '0);
    send_word(OP_DELETE, '1, '1);
    send_word(OP_DELETE, '0, '0);
    drain();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 500) hold_request = 1'b1;
      if (i == 1000) drain();
      quiet = (i >= 1300 && i < 1450);

      if ($urandom_range(0, 9) < 7)
        k = hot_tag[$urandom_range(0, 7)] * KEY_W'(NUM_BUCKETS)
            + KEY_W'(hot_bucket[$urandom_range(0, 7)]);
      else
        k = $urandom();
      v = $urandom();
      r = $urandom_range(0, 99);
      if (r < 40) begin
        op = OP_INSERT;
        if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 1) ? '0 : '1;
      end else if (r < 70) begin
        op = OP_FIND;
        if (recent_key.size() > 0 && $urandom_range(0, 1) == 1)
          k = recent_key[$urandom_range(0, recent_key.size() - 1)];
      end else if (r < 95) begin
        op = OP_DELETE;
        if (recent_key.size() > 0 && $urandom_range(0, 9) < 7) begin
          pick = $urandom_range(0, recent_key.size() - 1);
          k    = recent_key[pick];
          v    = recent_val[pick];
          if ($urandom_range(0, 4) == 0) v[$urandom_range(0, VAL_W - 1)] ^= 1'b1;
        end
      end else begin
        op = OP_UNUSED;
      end

      if (op == OP_INSERT) begin
        recent_key.push_back(k);
        recent_val.push_back(v);
        if (recent_key.size() > 32) begin
          void'(recent_key.pop_front());
          void'(recent_val.pop_front());
        end
      end
      send_word(op, k, v);
    end

    drain();
    repeat (SLOTS + 12) @(posedge clk);
    $display("%0d request words sent, %0d result words checked", sent, checked);
    $display("result mix: ok %0d, not found %0d, key exists %0d, bucket full %0d",
             status_count[ST_OK], status_count[ST_NOT_FOUND],
             status_count[ST_EXISTS], status_count[ST_FULL]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: bucketed_hash_table.f
src/bht_pkg.sv
src/bht_req_if.sv
src/bht_rsp_if.sv
src/bht_ram.sv
src/bht_mod.sv
src/bucketed_hash_table.sv
tb/hash_table_checker.sv
tb/testbench.sv
